FILE: design/qfct_pkg.sv
`timescale 1ns / 1ps

package qfct_pkg;

	// table geometry
	localparam int NODES = 256;
	localparam int IDX_W = $clog2(NODES);
	localparam int CNT_W = $clog2(NODES + 1);

	// stream field widths
	localparam int OP_W     = 2;
	localparam int NODE_FW  = 8;
	localparam int REACH_W  = 9;
	localparam int IN_DW    = 24;
	localparam int OUT_DW   = 16;

	typedef enum logic [OP_W-1:0] {
		OP_UNION = 2'd0,
		OP_QUERY = 2'd1,
		OP_MARK  = 2'd2,
		OP_COUNT = 2'd3
	} op_t;

	// one table entry: seed flag and component label
	typedef struct packed {
		logic             seed;
		logic [IDX_W-1:0] label;
	} entry_t;

	// access request to the component table
	typedef struct packed {
		logic             rd_en;
		logic [IDX_W-1:0] rd_addr;
		logic             wr_en;
		logic [IDX_W-1:0] wr_addr;
		entry_t           wr_data;
	} tbl_req_t;

endpackage

FILE: design/qfct_table.sv
`timescale 1ns / 1ps

module qfct_table import qfct_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  tbl_req_t req,
	output entry_t   rd_data
);

	entry_t           mem [NODES];
	logic [NODES-1:0] vld_q;
	entry_t           mem_s1;
	logic [IDX_W-1:0] addr_s1;
	logic             hit_s1;

	// storage and registered read port
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			mem_s1  <= mem[req.rd_addr];
			addr_s1 <= req.rd_addr;
			hit_s1  <= vld_q[req.rd_addr];
		end
	end

	// written-entry flags; an unwritten entry reads as its own index, unseeded
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (req.wr_en) begin
			vld_q[req.wr_addr] <= 1'b1;
		end
	end

	always_comb begin
		if (hit_s1) begin
			rd_data = mem_s1;
		end else begin
			rd_data.seed  = 1'b0;
			rd_data.label = addr_s1;
		end
	end

`ifndef ASSERT_OFF
	a_no_collision: assert property (@(posedge clk) disable iff (!arst_n)
		req.rd_en && req.wr_en |-> req.rd_addr != req.wr_addr)
		else $error("table read and write hit the same entry");

	a_write_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		req.wr_en |=> vld_q[$past(req.wr_addr)])
		else $error("written entry not flagged valid");

	a_valid_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> $countones(vld_q) >= $past($countones(vld_q)))
		else $error("valid flags dropped outside reset");
`endif

endmodule

FILE: design/quick_find_component_table_unit.sv
`timescale 1ns / 1ps

// channel   dir  fields (lsb first)                         beat taken when
// s_axis    in   tdata: operation[1:0] node_a[9:2] node_b   s_axis_tvalid & s_axis_tready
//                       [17:10], zero pad to 24
// m_axis    out  tdata: flag[0] reached_count[9:1],         m_axis_tvalid & m_axis_tready
//                       zero pad to 16
//
// One item at a time. Query and union read both labels and compare them; a merging
// union then sweeps the table to relabel, mark reads node_a and sets its seed flag,
// and count clears the root marks, then sweeps the table to mark seeded roots and
// again to tally. All table reads go through its single read port.
// Reset clears the written-entry flags, so every label reads as its own index.
// A stalled output holds its beat; the next input is taken once that beat moved
// into the output register, so one result may wait while the next item runs.

module quick_find_component_table_unit import qfct_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [IN_DW-1:0]  s_axis_tdata,   // operation, node_a, node_b
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [OUT_DW-1:0] m_axis_tdata    // flag, reached_count
);

	localparam logic [IDX_W:0] SWP_END  = (IDX_W + 1)'(NODES);
	localparam logic [IDX_W:0] SWP_LAST = (IDX_W + 1)'(NODES - 1);

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_RD_A  = 9'b000000010,
		S_RD_B  = 9'b000000100,
		S_CMP   = 9'b000001000,
		S_SWEEP = 9'b000010000,
		S_CLR   = 9'b000100000,
		S_MARKP = 9'b001000000,
		S_TALLY = 9'b010000000,
		S_RESP  = 9'b100000000
	} state_t;

	state_t               state_q;
	op_t                  op_q;
	logic [NODE_FW-1:0]   a_q;
	logic [NODE_FW-1:0]   b_q;
	logic [IDX_W-1:0]     keep_q;
	logic [IDX_W-1:0]     drop_q;
	logic [IDX_W:0]       cnt_q;
	logic [CNT_W-1:0]     seed_total_q;
	logic [CNT_W-1:0]     total_q;
	logic                 res_flag_q;
	logic [REACH_W-1:0]   res_cnt_q;
	logic                 out_vld_q;
	logic                 out_flag_q;
	logic [REACH_W-1:0]   out_cnt_q;

	// sweep pipeline: s1 = table data back, s2 = seeded-root flag back
	logic                 vld_s1;
	logic                 last_s1;
	logic [IDX_W-1:0]     addr_s1;
	logic                 vld_s2;
	logic                 last_s2;
	logic                 root_rd_s2;

	logic                 root_mem [NODES];
	logic                 root_wr_en;
	logic [IDX_W-1:0]     root_wr_addr;
	logic                 root_wr_data;

	tbl_req_t             req;
	entry_t               rd_data;
	logic                 sweeping;
	logic                 issue;
	logic                 is_last;
	logic                 in_beat;
	logic                 out_load;
	logic                 a_ok;
	logic                 b_ok;
	op_t                  in_op;
	logic [CNT_W-1:0]     total_nx;
	logic [CNT_W-1:0]     diff;
	logic [REACH_W-1:0]   reach_sat;

	qfct_table u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.rd_data (rd_data)
	);

	assign s_axis_tready = (state_q == S_IDLE);
	assign in_beat       = s_axis_tvalid && s_axis_tready;
	assign in_op         = op_t'(s_axis_tdata[1:0]);
	assign a_ok          = 32'(s_axis_tdata[9:2]) < NODES;
	assign b_ok          = 32'(s_axis_tdata[17:10]) < NODES;

	assign sweeping = (state_q == S_SWEEP) || (state_q == S_MARKP) || (state_q == S_TALLY);
	assign issue    = sweeping && (cnt_q < SWP_END);
	assign is_last  = (cnt_q == SWP_LAST);
	assign out_load = (state_q == S_RESP) && (!out_vld_q || m_axis_tready);

	// count result: reached nodes minus distinct seeds, floored at zero, saturated
	assign total_nx  = total_q + CNT_W'(root_rd_s2);
	assign diff      = (total_nx >= seed_total_q) ? total_nx - seed_total_q : '0;
	assign reach_sat = (32'(diff) > 32'd511) ? 9'd511 : REACH_W'(diff);

	// table port: single reads for operands, a seed write for mark, read-modify-write in the union sweep
	always_comb begin
		req          = '0;
		root_wr_en   = 1'b0;
		root_wr_addr = cnt_q[IDX_W-1:0];
		root_wr_data = 1'b0;
		unique case (state_q)
			S_RD_A: begin
				req.rd_en   = 1'b1;
				req.rd_addr = IDX_W'(a_q);
			end
			S_RD_B: begin
				if (op_q == OP_MARK) begin
					// set the seed flag once; keep the label
					req.wr_en         = !rd_data.seed;
					req.wr_addr       = IDX_W'(a_q);
					req.wr_data.seed  = 1'b1;
					req.wr_data.label = rd_data.label;
				end else begin
					req.rd_en   = 1'b1;
					req.rd_addr = IDX_W'(b_q);
				end
			end
			S_SWEEP: begin
				req.rd_en         = issue;
				req.rd_addr       = cnt_q[IDX_W-1:0];
				// relabel every entry of the dropped component
				req.wr_en         = vld_s1 && (rd_data.label == drop_q);
				req.wr_addr       = addr_s1;
				req.wr_data.seed  = rd_data.seed;
				req.wr_data.label = keep_q;
			end
			S_CLR: begin
				root_wr_en = 1'b1;
			end
			S_MARKP: begin
				req.rd_en    = issue;
				req.rd_addr  = cnt_q[IDX_W-1:0];
				// flag the component root of each seed
				root_wr_en   = vld_s1 && rd_data.seed;
				root_wr_addr = rd_data.label;
				root_wr_data = 1'b1;
			end
			S_TALLY: begin
				req.rd_en   = issue;
				req.rd_addr = cnt_q[IDX_W-1:0];
			end
			S_IDLE, S_CMP, S_RESP: begin
			end
			default: begin
			end
		endcase
	end

	// seeded-root marks
	always_ff @(posedge clk) begin
		if (root_wr_en) begin
			root_mem[root_wr_addr] <= root_wr_data;
		end
		if (vld_s1) begin
			root_rd_s2 <= root_mem[rd_data.label];
		end
		if (issue) begin
			addr_s1 <= cnt_q[IDX_W-1:0];
		end
	end

	// sweep pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			last_s1 <= 1'b0;
			vld_s2  <= 1'b0;
			last_s2 <= 1'b0;
		end else begin
			vld_s1  <= issue;
			last_s1 <= is_last;
			vld_s2  <= vld_s1 && (state_q == S_TALLY);
			last_s2 <= last_s1;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			op_q         <= OP_UNION;
			a_q          <= '0;
			b_q          <= '0;
			keep_q       <= '0;
			drop_q       <= '0;
			cnt_q        <= '0;
			seed_total_q <= '0;
			total_q      <= '0;
			res_flag_q   <= 1'b0;
			res_cnt_q    <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_beat) begin
						op_q       <= in_op;
						a_q        <= s_axis_tdata[9:2];
						b_q        <= s_axis_tdata[17:10];
						res_flag_q <= 1'b0;
						res_cnt_q  <= '0;
						cnt_q      <= '0;
						unique case (in_op)
							OP_UNION, OP_QUERY: begin
								state_q <= (a_ok && b_ok) ? S_RD_A : S_RESP;
							end
							OP_MARK: begin
								state_q <= a_ok ? S_RD_A : S_RESP;
							end
							OP_COUNT: begin
								state_q <= S_CLR;
							end
							default: begin
								state_q <= S_RESP;
							end
						endcase
					end
				end
				S_RD_A: begin
					state_q <= S_RD_B;
				end
				S_RD_B: begin
					keep_q <= rd_data.label;
					if (op_q == OP_MARK) begin
						if (!rd_data.seed) begin
							seed_total_q <= seed_total_q + 1'b1;
						end
						state_q <= S_RESP;
					end else begin
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					drop_q <= rd_data.label;
					if (keep_q == rd_data.label) begin
						res_flag_q <= (op_q == OP_QUERY);
						state_q    <= S_RESP;
					end else if (op_q == OP_QUERY) begin
						state_q <= S_RESP;
					end else begin
						res_flag_q <= 1'b1;
						state_q    <= S_SWEEP;
					end
				end
				S_SWEEP: begin
					if (issue) begin
						cnt_q <= cnt_q + 1'b1;
					end
					if (vld_s1 && last_s1) begin
						state_q <= S_RESP;
					end
				end
				S_CLR: begin
					// wipe root marks left by the previous count
					if (is_last) begin
						cnt_q   <= '0;
						state_q <= S_MARKP;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_MARKP: begin
					if (issue) begin
						cnt_q <= cnt_q + 1'b1;
					end
					if (vld_s1 && last_s1) begin
						cnt_q   <= '0;
						total_q <= '0;
						state_q <= S_TALLY;
					end
				end
				S_TALLY: begin
					if (issue) begin
						cnt_q <= cnt_q + 1'b1;
					end
					if (vld_s2) begin
						total_q <= total_nx;
					end
					if (vld_s2 && last_s2) begin
						res_cnt_q <= reach_sat;
						state_q   <= S_RESP;
					end
				end
				S_RESP: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// output register: hold the beat until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			out_flag_q <= 1'b0;
			out_cnt_q  <= '0;
		end else begin
			if (out_load) begin
				out_vld_q  <= 1'b1;
				out_flag_q <= res_flag_q;
				out_cnt_q  <= res_cnt_q;
			end else if (m_axis_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {(OUT_DW - REACH_W - 1)'(0), out_cnt_q, out_flag_q};

endmodule
